// ===== hdl/dstack_pkg.sv =====
// shared types and constants of the data stack
package dstack_pkg;

   localparam int OP_W     = 3;
   localparam int OFFSET_W = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_DUP  = 3'd2,
      OP_SWAP = 3'd3,
      OP_ROT  = 3'd4,
      OP_PEEK = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   // how the row of cells moves on an accepted request
   typedef enum logic [2:0] {
      MV_HOLD,
      MV_PUSH,
      MV_POP,
      MV_DUP,
      MV_SWAP,
      MV_ROT
   } move_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_TOP,
      RD_PEEK
   } read_sel_type;

   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_PREV,
      SEL_NEXT,
      SEL_ALT
   } cell_sel_type;

   typedef struct packed {
      move_type     move;
      status_type   status;
      read_sel_type read_sel;
   } ctrl_type;

endpackage

// ===== hdl/dstack_chan_if.sv =====
// request and response channel interfaces of the data stack
interface dstack_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                               valid;
   logic                               ready;
   logic [dstack_pkg::OP_W-1:0]        operation;
   logic [DATA_WIDTH-1:0]              push_value;
   logic [dstack_pkg::OFFSET_W-1:0]    peek_offset;

   modport source (output valid, operation, push_value, peek_offset, input ready);
   modport sink   (input valid, operation, push_value, peek_offset, output ready);
endinterface

interface dstack_rsp_if #(
   parameter int DATA_WIDTH = 32,
   parameter int COUNT_W    = 5
);
   logic                               valid;
   logic                               ready;
   logic [DATA_WIDTH-1:0]              read_value;
   logic [dstack_pkg::STATUS_W-1:0]    status;
   logic [COUNT_W-1:0]                 depth;

   modport source (output valid, read_value, status, depth, input ready);
   modport sink   (input valid, read_value, status, depth, output ready);
endinterface

// ===== hdl/data_stack_dup_swap_rot_peek.sv =====
// top level of the bounded data stack with push, pop, dup, swap, rot and peek
//
//   channel   dir  handshake           payload
//   req_chan  in   valid / ready       operation, push_value, peek_offset
//   rsp_chan  out  valid / ready       read_value, status, depth
//
// one request per cycle: the cells and the count update at the accepting edge
// and the response sits in an output register from the next cycle on.
// the stack is a row of DEPTH cells with the top entry in cell 0; every
// operation is one parallel move of the row, so rot costs the same as push.
// a request is taken while the response register is empty or being drained.
// reset empties the stack and the response register; cell contents are kept.
module data_stack_dup_swap_rot_peek #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   dstack_req_if.sink   req_chan,
   dstack_rsp_if.source rsp_chan
);

   localparam int COUNT_W   = $clog2(DEPTH + 1);
   localparam int PEEK_SPAN = (DEPTH < (1 << dstack_pkg::OFFSET_W)) ?
                              DEPTH : (1 << dstack_pkg::OFFSET_W);

   logic                                accept;
   logic [COUNT_W-1:0]                  count_ff;
   logic [COUNT_W-1:0]                  count_in;
   dstack_pkg::ctrl_type                ctrl;
   logic [DATA_WIDTH-1:0]               cell_value [DEPTH];
   logic [DATA_WIDTH-1:0]               alt_value;
   logic [DATA_WIDTH-1:0]               peek_value;
   logic [DATA_WIDTH-1:0]               read_value;

   logic                                rsp_valid_ff;
   logic [DATA_WIDTH-1:0]               read_value_ff;
   logic [dstack_pkg::STATUS_W-1:0]     status_ff;
   logic [COUNT_W-1:0]                  depth_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   dstack_ctrl #(
      .DEPTH   (DEPTH),
      .COUNT_W (COUNT_W)
   ) u_ctrl (
      .operation   (req_chan.operation),
      .peek_offset (req_chan.peek_offset),
      .count       (count_ff),
      .ctrl        (ctrl),
      .count_next  (count_in)
   );

   // only cell 0 uses the alternate input
   assign alt_value = (ctrl.move == dstack_pkg::MV_ROT) ? cell_value[2] : req_chan.push_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_value;
      logic [DATA_WIDTH-1:0] next_value;
      logic [DATA_WIDTH-1:0] cell_alt;

      if (i == 0) begin : g_first
         assign prev_value = '0;
         assign cell_alt   = alt_value;
      end else begin : g_rest
         assign prev_value = cell_value[i-1];
         assign cell_alt   = '0;
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      dstack_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .enable     (accept),
         .move       (ctrl.move),
         .prev_value (prev_value),
         .next_value (next_value),
         .alt_value  (cell_alt),
         .value      (cell_value[i])
      );
   end

   always_comb begin
      peek_value = '0;
      for (int i = 0; i < PEEK_SPAN; i++) begin
         if (req_chan.peek_offset == dstack_pkg::OFFSET_W'(i)) begin
            peek_value = cell_value[i];
         end
      end
   end

   always_comb begin
      unique case (ctrl.read_sel)
         dstack_pkg::RD_TOP:  read_value = cell_value[0];
         dstack_pkg::RD_PEEK: read_value = peek_value;
         default:             read_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value;
         status_ff     <= ctrl.status;
         depth_ff      <= count_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = read_value_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.depth      = depth_ff;

endmodule

// ===== hdl/dstack_cell.sv =====
// one stack entry cell, loads from itself, a neighbour or the alternate input
module dstack_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  enable,
   input  dstack_pkg::move_type  move,
   input  logic [DATA_WIDTH-1:0] prev_value,
   input  logic [DATA_WIDTH-1:0] next_value,
   input  logic [DATA_WIDTH-1:0] alt_value,
   output logic [DATA_WIDTH-1:0] value
);

   logic [DATA_WIDTH-1:0]    value_ff;
   logic [DATA_WIDTH-1:0]    value_in;
   dstack_pkg::cell_sel_type sel;

   always_comb begin
      unique case (move)
         dstack_pkg::MV_PUSH: sel = (INDEX == 0) ? dstack_pkg::SEL_ALT : dstack_pkg::SEL_PREV;
         dstack_pkg::MV_POP:  sel = dstack_pkg::SEL_NEXT;
         dstack_pkg::MV_DUP:  sel = (INDEX == 0) ? dstack_pkg::SEL_HOLD : dstack_pkg::SEL_PREV;
         dstack_pkg::MV_SWAP: begin
            if (INDEX == 0)      sel = dstack_pkg::SEL_NEXT;
            else if (INDEX == 1) sel = dstack_pkg::SEL_PREV;
            else                 sel = dstack_pkg::SEL_HOLD;
         end
         // top takes the third entry, the next two move down one place
         dstack_pkg::MV_ROT: begin
            if (INDEX == 0)                   sel = dstack_pkg::SEL_ALT;
            else if (INDEX == 1 || INDEX == 2) sel = dstack_pkg::SEL_PREV;
            else                              sel = dstack_pkg::SEL_HOLD;
         end
         default: sel = dstack_pkg::SEL_HOLD;
      endcase
   end

   always_comb begin
      unique case (sel)
         dstack_pkg::SEL_PREV: value_in = prev_value;
         dstack_pkg::SEL_NEXT: value_in = next_value;
         dstack_pkg::SEL_ALT:  value_in = alt_value;
         default:              value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== hdl/dstack_ctrl.sv =====
// decodes a request against the entry count into move, status, read select and new count
module dstack_ctrl #(
   parameter int DEPTH   = 16,
   parameter int COUNT_W = 5
) (
   input  logic [dstack_pkg::OP_W-1:0]     operation,
   input  logic [dstack_pkg::OFFSET_W-1:0] peek_offset,
   input  logic [COUNT_W-1:0]              count,
   output dstack_pkg::ctrl_type            ctrl,
   output logic [COUNT_W-1:0]              count_next
);

   localparam int CMP_W = (COUNT_W > dstack_pkg::OFFSET_W) ? COUNT_W : dstack_pkg::OFFSET_W;

   logic full;
   logic empty;
   logic below_two;
   logic below_three;
   logic offset_out;

   assign full        = (count == COUNT_W'(DEPTH));
   assign empty       = (count == '0);
   assign below_two   = (count < COUNT_W'(2));
   assign below_three = (count < COUNT_W'(3));
   assign offset_out  = (CMP_W'(peek_offset) >= CMP_W'(count));

   always_comb begin
      ctrl.move     = dstack_pkg::MV_HOLD;
      ctrl.status   = dstack_pkg::ST_OK;
      ctrl.read_sel = dstack_pkg::RD_NONE;
      count_next    = count;
      unique case (dstack_pkg::op_type'(operation))
         dstack_pkg::OP_PUSH: begin
            if (full) begin
               ctrl.status = dstack_pkg::ST_OVER;
            end else begin
               ctrl.move  = dstack_pkg::MV_PUSH;
               count_next = count + COUNT_W'(1);
            end
         end
         dstack_pkg::OP_POP: begin
            if (empty) begin
               ctrl.status = dstack_pkg::ST_UNDER;
            end else begin
               ctrl.move     = dstack_pkg::MV_POP;
               ctrl.read_sel = dstack_pkg::RD_TOP;
               count_next    = count - COUNT_W'(1);
            end
         end
         dstack_pkg::OP_DUP: begin
            if (empty) begin
               ctrl.status = dstack_pkg::ST_UNDER;
            end else if (full) begin
               ctrl.status = dstack_pkg::ST_OVER;
            end else begin
               ctrl.move  = dstack_pkg::MV_DUP;
               count_next = count + COUNT_W'(1);
            end
         end
         dstack_pkg::OP_SWAP: begin
            if (below_two) ctrl.status = dstack_pkg::ST_UNDER;
            else           ctrl.move   = dstack_pkg::MV_SWAP;
         end
         dstack_pkg::OP_ROT: begin
            if (below_three) ctrl.status = dstack_pkg::ST_UNDER;
            else             ctrl.move   = dstack_pkg::MV_ROT;
         end
         dstack_pkg::OP_PEEK: begin
            if (offset_out) ctrl.status   = dstack_pkg::ST_UNDER;
            else            ctrl.read_sel = dstack_pkg::RD_PEEK;
         end
         default: ctrl.status = dstack_pkg::ST_UNDER;
      endcase
   end

endmodule

// ===== sim/data_stack_dup_swap_rot_peek_test.sv =====
// testbench of the bounded data stack: shadow stack, random traffic, response checks
`timescale 1ns / 100ps

module data_stack_dup_swap_rot_peek_test;

   localparam int STACK_DEPTH = 16;
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 5;
   localparam int OP_W        = dstack_pkg::OP_W;
   localparam int OFFSET_W    = dstack_pkg::OFFSET_W;
   localparam int STATUS_W    = dstack_pkg::STATUS_W;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 80;
   localparam int DRAIN_WAIT  = 20;

   // operation codes the block does not implement
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct {
      logic [WORD_W-1:0]      read_value;
      dstack_pkg::status_type status;
      logic [COUNT_W-1:0]     depth;
   } stack_reply_type;

   class stack_mirror_type;
      logic [WORD_W-1:0] cells [STACK_DEPTH];  // index 0 is the bottom entry
      int unsigned       held;
      stack_reply_type   replies_due [$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       underflows;
      int unsigned       overflows;

      function new();
         held       = 0;
         errors     = 0;
         checked    = 0;
         underflows = 0;
         overflows  = 0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                                 logic [OFFSET_W-1:0] offset);
         stack_reply_type   want;
         logic [WORD_W-1:0] a;
         want.read_value = '0;
         want.status     = dstack_pkg::ST_OK;
         case (op)
            dstack_pkg::OP_PUSH: begin
               if (held >= STACK_DEPTH) want.status = dstack_pkg::ST_OVER;
               else begin
                  cells[held] = value;
                  held++;
               end
            end
            dstack_pkg::OP_POP: begin
               if (held == 0) want.status = dstack_pkg::ST_UNDER;
               else begin
                  held--;
                  want.read_value = cells[held];
               end
            end
            dstack_pkg::OP_DUP: begin
               if (held == 0) want.status = dstack_pkg::ST_UNDER;
               else if (held >= STACK_DEPTH) want.status = dstack_pkg::ST_OVER;
               else begin
                  cells[held] = cells[held-1];
                  held++;
               end
            end
            dstack_pkg::OP_SWAP: begin
               if (held < 2) want.status = dstack_pkg::ST_UNDER;
               else begin
                  a              = cells[held-1];
                  cells[held-1]  = cells[held-2];
                  cells[held-2]  = a;
               end
            end
            dstack_pkg::OP_ROT: begin
               // a b c with c on top becomes b c a
               if (held < 3) want.status = dstack_pkg::ST_UNDER;
               else begin
                  a             = cells[held-3];
                  cells[held-3] = cells[held-2];
                  cells[held-2] = cells[held-1];
                  cells[held-1] = a;
               end
            end
            dstack_pkg::OP_PEEK: begin
               if (offset >= held) want.status = dstack_pkg::ST_UNDER;
               else want.read_value = cells[held-1-offset];
            end
            default: want.status = dstack_pkg::ST_UNDER;
         endcase
         if (want.status == dstack_pkg::ST_UNDER) underflows++;
         if (want.status == dstack_pkg::ST_OVER) overflows++;
         want.depth = held[COUNT_W-1:0];
         replies_due.push_back(want);
      endfunction

      task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] wanted);
         $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, wanted);
         errors++;
      endtask

      task check_reply(logic [WORD_W-1:0] value, logic [STATUS_W-1:0] status,
                       logic [COUNT_W-1:0] depth);
         stack_reply_type want;
         checked++;
         if (replies_due.size() == 0) begin
            report("response with no request outstanding", value, '0);
         end else begin
            want = replies_due.pop_front();
            if (value !== want.read_value) report("read_value", value, want.read_value);
            if (status !== want.status)
               report("status", WORD_W'(status), WORD_W'(want.status));
            if (depth !== want.depth)
               report("depth", WORD_W'(depth), WORD_W'(want.depth));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   dstack_req_if #(.DATA_WIDTH(WORD_W)) req_chan ();
   dstack_rsp_if #(.DATA_WIDTH(WORD_W), .COUNT_W(COUNT_W)) rsp_chan ();

   data_stack_dup_swap_rot_peek #(
      .DEPTH      (STACK_DEPTH),
      .DATA_WIDTH (WORD_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stack_mirror_type mirror;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_asked    = 0;
   int unsigned hold_taken    = 0;
   int unsigned stall_left    = 0;
   int unsigned requests_sent = 0;

   // response side: random back-pressure, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_taken != hold_asked) begin
         rsp_chan.ready <= 1'b0;
         hold_taken     <= hold_asked;
         stall_left     <= LONG_HOLD;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         mirror.check_reply(rsp_chan.read_value, rsp_chan.status, rsp_chan.depth);
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
             || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                               input logic [OFFSET_W-1:0] offset);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.push_value  <= value;
      req_chan.peek_offset <= offset;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      mirror.note_request(op, value, offset);
      requests_sent++;
   endtask

   task automatic run_directed();
      send_request(dstack_pkg::OP_POP, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_DUP, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_SWAP, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_ROT, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_PEEK, 32'h0, 4'd0);
      send_request(OP_UNUSED_LO, 32'hFFFF_FFFF, 4'd15);
      send_request(OP_UNUSED_HI, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_PUSH, 32'h0, 4'd15);
      send_request(dstack_pkg::OP_SWAP, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd0);
      send_request(dstack_pkg::OP_ROT, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_PUSH, 32'hA5C3_3C5A, 4'd0);
      send_request(dstack_pkg::OP_ROT, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_SWAP, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_PEEK, 32'h0, 4'd2);
      send_request(dstack_pkg::OP_PEEK, 32'h0, 4'd3);
      send_request(dstack_pkg::OP_DUP, 32'h0, 4'd0);
      while (mirror.held < STACK_DEPTH) send_request(dstack_pkg::OP_PUSH, $urandom, 4'd0);
      send_request(dstack_pkg::OP_PUSH, 32'h1234_5678, 4'd0);
      send_request(dstack_pkg::OP_DUP, 32'h0, 4'd0);
      send_request(dstack_pkg::OP_PEEK, 32'h0, 4'd15);
      send_request(dstack_pkg::OP_POP, 32'h0, 4'd0);
   endtask

   // swings between filling and draining so that both ends of the stack get hit
   task automatic run_random(input int unsigned count);
      bit                  filling;
      int unsigned         pick;
      logic [OP_W-1:0]     op;
      logic [WORD_W-1:0]   value;
      logic [OFFSET_W-1:0] offset;
      filling = 1'b1;
      repeat (count) begin
         if (filling && mirror.held == STACK_DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
         else if (!filling && mirror.held == 0 && $urandom_range(3) == 0)
            filling = 1'b1;
         else if ($urandom_range(59) == 0)
            filling = !filling;
         pick = $urandom_range(99);
         if (filling) begin
            if (pick < 40)      op = dstack_pkg::OP_PUSH;
            else if (pick < 50) op = dstack_pkg::OP_DUP;
            else if (pick < 62) op = dstack_pkg::OP_SWAP;
            else if (pick < 74) op = dstack_pkg::OP_ROT;
            else if (pick < 90) op = dstack_pkg::OP_PEEK;
            else if (pick < 97) op = dstack_pkg::OP_POP;
            else if (pick < 98) op = OP_UNUSED_LO;
            else                op = OP_UNUSED_HI;
         end else begin
            if (pick < 10)      op = dstack_pkg::OP_PUSH;
            else if (pick < 14) op = dstack_pkg::OP_DUP;
            else if (pick < 24) op = dstack_pkg::OP_SWAP;
            else if (pick < 34) op = dstack_pkg::OP_ROT;
            else if (pick < 50) op = dstack_pkg::OP_PEEK;
            else if (pick < 97) op = dstack_pkg::OP_POP;
            else if (pick < 98) op = OP_UNUSED_LO;
            else                op = OP_UNUSED_HI;
         end
         pick = $urandom_range(9);
         if (pick == 0)      value = '0;
         else if (pick == 1) value = '1;
         else                value = $urandom;
         if (mirror.held > 0 && $urandom_range(3) != 0)
            offset = OFFSET_W'($urandom_range(mirror.held - 1));
         else
            offset = OFFSET_W'($urandom_range(15));
         send_request(op, value, offset);
      end
   endtask

   initial begin
      int unsigned saved_pct;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= dstack_pkg::OP_PUSH;
      req_chan.push_value  <= '0;
      req_chan.peek_offset <= '0;
      mirror = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 58;
      run_directed();
      run_random(520);

      // hold responses back while requests keep coming, so the input stalls
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      hold_asked++;
      run_random(40);
      send_idle_pct = saved_pct;

      send_idle_pct = 58;
      recv_idle_pct = 18;
      run_random(540);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(520);

      req_chan.valid <= 1'b0;
      while (mirror.replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, mirror.checked, mirror.errors);
      $display("underflow or out-of-range replies: %0d, overflow replies: %0d",
               mirror.underflows, mirror.overflows);
      if (mirror.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
